// File: rtl/core/lps_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and codes for the fixed-point line stepper.
// Depends on nothing; every other file of the block uses it.
package lps_pkg;

    localparam int COORD_BITS     = 10;
    localparam int FRAC_BITS      = 10;
    localparam int ACC_BITS       = COORD_BITS + FRAC_BITS + 2;
    localparam int STEP_BITS      = FRAC_BITS + 2;
    localparam int CNT_BITS       = COORD_BITS + 1;
    localparam int NUM_BITS       = CNT_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS   = $clog2(NUM_BITS + 1);
    localparam int OUT_COORD_BITS = 11;
    localparam int OUT_ADDR_BITS  = 21;
    localparam int STRIDE_BITS    = 11;
    localparam int COLOR_BITS     = 8;
    localparam int PROD_BITS      = OUT_COORD_BITS + STRIDE_BITS + 1;

    typedef logic        [COORD_BITS-1:0]     coord_t;
    typedef logic        [CNT_BITS-1:0]       cnt_t;
    typedef logic signed [STEP_BITS-1:0]      step_t;
    typedef logic signed [ACC_BITS-1:0]       acc_t;
    typedef logic        [NUM_BITS-1:0]       num_t;
    typedef logic        [COLOR_BITS-1:0]     color_t;
    typedef logic        [STRIDE_BITS-1:0]    stride_t;
    typedef logic signed [OUT_COORD_BITS-1:0] out_coord_t;
    typedef logic signed [OUT_ADDR_BITS-1:0]  out_addr_t;

    localparam logic OP_LINE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam stride_t STRIDE_RESET = STRIDE_BITS'(1024);
    localparam step_t   UNIT_STEP    = step_t'(1) <<< FRAC_BITS;

endpackage

// File: rtl/core/lps_cmd_if.sv
`timescale 1ns / 1ps
// Command channel of the line stepper: valid/ready handshake plus payload.
// Depends on lps_pkg.
interface lps_cmd_if;
    logic             valid;
    logic             ready;
    logic             op;
    lps_pkg::coord_t  start_x;
    lps_pkg::coord_t  start_y;
    lps_pkg::coord_t  end_x;
    lps_pkg::coord_t  end_y;
    lps_pkg::color_t  line_color;

    modport source (output valid, op, start_x, start_y, end_x, end_y, line_color,
                    input ready);
    modport sink   (input valid, op, start_x, start_y, end_x, end_y, line_color,
                    output ready);
endinterface

// File: rtl/core/lps_pixel_if.sv
`timescale 1ns / 1ps
// Pixel channel of the line stepper: valid/ready handshake plus payload.
// Depends on lps_pkg.
interface lps_pixel_if;
    logic                 valid;
    logic                 ready;
    lps_pkg::out_coord_t  pixel_x;
    lps_pkg::out_coord_t  pixel_y;
    lps_pkg::out_addr_t   pixel_address;
    lps_pkg::color_t      pixel_color;
    logic                 last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color,
                    last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color,
                    last_pixel, output ready);
endinterface

// File: rtl/core/lps_divider.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lps_pkg.
module lps_divider
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  lps_pkg::num_t   numerator,
    input  lps_pkg::cnt_t   denominator,
    output logic            done,
    output lps_pkg::num_t   quotient
);
    import lps_pkg::*;

    logic                    busy_reg,  busy_next;
    logic                    done_reg,  done_next;
    logic [DIV_CNT_BITS-1:0] count_reg, count_next;
    cnt_t                    rem_reg,   rem_next;
    cnt_t                    den_reg,   den_next;
    num_t                    quo_reg,   quo_next;
    logic [CNT_BITS:0]       trial;
    logic [CNT_BITS:0]       trial_diff;

    always_comb
    begin
        trial      = {rem_reg, quo_reg[NUM_BITS-1]};
        trial_diff = trial - {1'b0, den_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = DIV_CNT_BITS'(NUM_BITS);
            rem_next   = '0;
            den_next   = denominator;
            quo_next   = numerator;
        end
        else if (busy_reg)
        begin
            // Bring down the next numerator bit and subtract when it fits.
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial_diff[CNT_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/fixed_point_line_stepper.sv
`timescale 1ns / 1ps
// Top level of the fixed-point DDA line stepper.
// Depends on lps_pkg, lps_cmd_if, lps_pixel_if and lps_divider.
//
// Usage: the cmd channel takes two kinds of transfer. A line command (op 0)
// loads both endpoints and a color and produces no pixel. A tick (op 1) asks
// for the next pixel of the active line; the pixel channel then carries its
// coordinates, its buffer address y*row_stride+x, the color and a last flag.
// A tick with no active line is consumed without a pixel, and a new line
// command replaces any active line at once.
// Flow: a pixel is registered and appears on the pixel channel in the cycle
// after its tick transfer; ticks are taken one per cycle while the receiver
// keeps up and no line is being divided. A line command drops cmd.ready
// while the divider produces the minor-axis step, one quotient bit per cycle.
// The output register lets a tick be taken while the previous pixel is still
// waiting, as long as that pixel leaves in the same cycle; if the receiver
// stalls, cmd.ready stays low until the waiting pixel is taken. Reset clears
// the line state (no active line) and sets row_stride to 1024. The user must
// write row_stride via cfg_we/cfg_wdata only while idle; it is not enforced.
module fixed_point_line_stepper
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  lps_pkg::stride_t  cfg_wdata,
    lps_cmd_if.sink           cmd,
    lps_pixel_if.source       pixel
);
    import lps_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_DIVIDE = 1'b1;

    logic        state_reg, state_next;
    stride_t     stride_reg;
    acc_t        x_acc_reg, x_acc_next;
    acc_t        y_acc_reg, y_acc_next;
    step_t       x_step_reg, x_step_next;
    step_t       y_step_reg, y_step_next;
    cnt_t        remain_reg, remain_next;
    color_t      color_reg, color_next;
    logic        x_major_reg, x_major_next;
    logic        minor_neg_reg, minor_neg_next;

    logic        out_valid_reg, out_valid_next;
    out_coord_t  out_x_reg;
    out_coord_t  out_y_reg;
    out_addr_t   out_addr_reg;
    color_t      out_color_reg;
    logic        out_last_reg;

    // Command decode.
    logic        take;
    logic        emit;
    coord_t      adx, ady;
    logic        x_major;
    cnt_t        major_len;
    cnt_t        minor_mag;
    logic        minor_neg;
    num_t        div_num;
    logic        div_done;
    num_t        div_quo;
    step_t       minor_step;

    // Pixel arithmetic.
    out_coord_t            px, py;
    logic signed [PROD_BITS-1:0] addr_prod;
    out_addr_t             addr;

    assign cmd.ready = (state_reg == ST_IDLE) && (!out_valid_reg || pixel.ready);
    assign take      = cmd.valid && cmd.ready;
    assign emit      = take && (cmd.op == OP_TICK) && (remain_reg != '0);

    always_comb
    begin
        adx = (cmd.end_x >= cmd.start_x) ? cmd.end_x - cmd.start_x
                                         : cmd.start_x - cmd.end_x;
        ady = (cmd.end_y >= cmd.start_y) ? cmd.end_y - cmd.start_y
                                         : cmd.start_y - cmd.end_y;
        x_major = (adx >= ady);
        if (x_major)
        begin
            major_len = {1'b0, adx} + 1'b1;
            minor_mag = {1'b0, ady} + 1'b1;
            minor_neg = (cmd.start_y > cmd.end_y);
        end
        else
        begin
            major_len = {1'b0, ady} + 1'b1;
            minor_mag = {1'b0, adx} + 1'b1;
            minor_neg = (cmd.start_x > cmd.end_x);
        end
        // Magnitude of (delta + 1) scaled by the fraction; the sign is
        // applied after the division, which truncates toward zero.
        div_num = {minor_mag, {FRAC_BITS{1'b0}}};
    end

    lps_divider u_divider
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (take && (cmd.op == OP_LINE)),
        .numerator   (div_num),
        .denominator (major_len),
        .done        (div_done),
        .quotient    (div_quo)
    );

    assign minor_step = minor_neg_reg ? -step_t'(div_quo[STEP_BITS-1:0])
                                      :  step_t'(div_quo[STEP_BITS-1:0]);

    // Pixel coordinates are the accumulators shifted right arithmetically.
    assign px        = OUT_COORD_BITS'(x_acc_reg >>> FRAC_BITS);
    assign py        = OUT_COORD_BITS'(y_acc_reg >>> FRAC_BITS);
    assign addr_prod = PROD_BITS'(py) * $signed(PROD_BITS'(stride_reg));
    assign addr      = OUT_ADDR_BITS'(addr_prod + PROD_BITS'(px));

    always_comb
    begin
        state_next     = state_reg;
        x_acc_next     = x_acc_reg;
        y_acc_next     = y_acc_reg;
        x_step_next    = x_step_reg;
        y_step_next    = y_step_reg;
        remain_next    = remain_reg;
        color_next     = color_reg;
        x_major_next   = x_major_reg;
        minor_neg_next = minor_neg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && (cmd.op == OP_LINE))
                begin
                    // Load everything but the minor step, which the divider
                    // delivers later.
                    x_acc_next     = acc_t'({cmd.start_x, {FRAC_BITS{1'b0}}});
                    y_acc_next     = acc_t'({cmd.start_y, {FRAC_BITS{1'b0}}});
                    remain_next    = major_len;
                    color_next     = cmd.line_color;
                    x_major_next   = x_major;
                    minor_neg_next = minor_neg;
                    if (x_major)
                    begin
                        x_step_next = (cmd.start_x > cmd.end_x) ? -UNIT_STEP : UNIT_STEP;
                    end
                    else
                    begin
                        y_step_next = (cmd.start_y > cmd.end_y) ? -UNIT_STEP : UNIT_STEP;
                    end
                    state_next = ST_DIVIDE;
                end
                else if (emit)
                begin
                    x_acc_next  = x_acc_reg + ACC_BITS'(x_step_reg);
                    y_acc_next  = y_acc_reg + ACC_BITS'(y_step_reg);
                    remain_next = remain_reg - 1'b1;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    if (x_major_reg)
                    begin
                        y_step_next = minor_step;
                    end
                    else
                    begin
                        x_step_next = minor_step;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stride_reg    <= STRIDE_RESET;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            x_step_reg    <= '0;
            y_step_reg    <= '0;
            remain_reg    <= '0;
            color_reg     <= '0;
            x_major_reg   <= 1'b0;
            minor_neg_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                stride_reg <= cfg_wdata;
            end
            x_acc_reg     <= x_acc_next;
            y_acc_reg     <= y_acc_next;
            x_step_reg    <= x_step_next;
            y_step_reg    <= y_step_next;
            remain_reg    <= remain_next;
            color_reg     <= color_next;
            x_major_reg   <= x_major_next;
            minor_neg_reg <= minor_neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg     <= px;
            out_y_reg     <= py;
            out_addr_reg  <= addr;
            out_color_reg <= color_reg;
            out_last_reg  <= (remain_reg == CNT_BITS'(1));
        end
    end

    assign pixel.valid         = out_valid_reg;
    assign pixel.pixel_x       = out_x_reg;
    assign pixel.pixel_y       = out_y_reg;
    assign pixel.pixel_address = out_addr_reg;
    assign pixel.pixel_color   = out_color_reg;
    assign pixel.last_pixel    = out_last_reg;

endmodule
